/* design/bfa_pkg.sv */
`timescale 1ns / 1ps

package bfa_pkg;

    // Fixed field widths of the ports.
    localparam int FRAME_W  = 12;
    localparam int LIMIT_W  = 13;
    localparam int STATUS_W = 2;

    // Default sizing of the bitmap.
    localparam int MAX_FRAMES_DEF = 4096;
    localparam int WORD_BITS_DEF  = 32;
    localparam int MAP_WORDS_DEF  = 128;

    // Widest bitmap word the bit search handles.
    localparam int MAX_WORD_BITS = 64;
    localparam int MAX_BIDX_W    = $clog2(MAX_WORD_BITS);

    // Reset value of the frame limit register.
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

    // Request kinds.
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_FREE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd2;

    // One result transaction.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FRAME_W-1:0]  frame_out;
    } res_t;

    // Index of the lowest clear bit; the caller pads unused upper bits with ones.
    function automatic logic [MAX_BIDX_W-1:0] lowest_zero(input logic [MAX_WORD_BITS-1:0] w);
        logic [MAX_BIDX_W-1:0] idx;
        idx = '0;
        for (int i = MAX_WORD_BITS - 1; i >= 0; i--)
        begin
            if (!w[i])
            begin
                idx = MAX_BIDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

/* design/bfa_map_mem.sv */
`timescale 1ns / 1ps

module bfa_map_mem #(
    parameter int WORD_BITS = 32,
    parameter int MAP_WORDS = 128,
    localparam int WIDX_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  logic [WIDX_W-1:0]    rd_addr,
    output logic [WORD_BITS-1:0] rd_data,
    input  logic                 wr_en,
    input  logic [WIDX_W-1:0]    wr_addr,
    input  logic [WORD_BITS-1:0] wr_data
);

    logic [WORD_BITS-1:0] map_reg [MAP_WORDS];
    logic [MAP_WORDS-1:0] valid_reg;
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 rd_valid_reg;

    // Bitmap storage; one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            map_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= map_reg[rd_addr];
        end
    end

    // A word that was never written reads as all free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

/* design/bfa_ctrl.sv */
`timescale 1ns / 1ps

module bfa_ctrl #(
    parameter int MAX_FRAMES = 4096,
    parameter int WORD_BITS  = 32,
    parameter int MAP_WORDS  = 128,
    localparam int WIDX_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         cmd,
    input  logic [bfa_pkg::FRAME_W-1:0]  frame,
    input  logic [bfa_pkg::LIMIT_W-1:0]  cfg_limit,
    output logic                         rd_en,
    output logic [WIDX_W-1:0]            rd_addr,
    input  logic [WORD_BITS-1:0]         rd_data,
    output logic                         wr_en,
    output logic [WIDX_W-1:0]            wr_addr,
    output logic [WORD_BITS-1:0]         wr_data,
    output logic                         res_valid,
    input  logic                         res_take,
    output bfa_pkg::res_t                res
);

    import bfa_pkg::*;

    localparam int ICNT_W  = $clog2(MAP_WORDS + 1);
    localparam int BIDX_W  = $clog2(WORD_BITS);
    localparam int CAP     = MAP_WORDS * WORD_BITS;
    localparam int LIM_CAP = (MAX_FRAMES < CAP) ? MAX_FRAMES : CAP;
    localparam int BASE_W  = $clog2(CAP + WORD_BITS + 1);
    localparam int CMP_W   = (BASE_W > LIMIT_W) ? BASE_W : LIMIT_W;

    localparam logic [CMP_W-1:0]  LIM_CAP_V = CMP_W'(LIM_CAP);
    localparam logic [CMP_W-1:0]  WB_V      = CMP_W'(WORD_BITS);
    localparam logic [BASE_W-1:0] WB_STEP   = BASE_W'(WORD_BITS);
    localparam logic [ICNT_W-1:0] WORDS_V   = ICNT_W'(MAP_WORDS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_FWALK = 3'd2;
    localparam logic [2:0] S_FMOD  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [FRAME_W-1:0]  frame_reg, frame_next;
    logic [CMP_W-1:0]    limit_reg, limit_next;
    logic [ICNT_W-1:0]   iss_w_reg, iss_w_next;
    logic [BASE_W-1:0]   iss_base_reg, iss_base_next;
    logic                chk_pend_reg, chk_pend_next;
    logic [WIDX_W-1:0]   chk_w_reg, chk_w_next;
    logic [BASE_W-1:0]   chk_base_reg, chk_base_next;
    logic [BIDX_W-1:0]   bit_reg, bit_next;
    res_t                res_reg, res_next;

    logic [CMP_W-1:0]    limit_in;
    logic [CMP_W-1:0]    frame_ext;
    logic [CMP_W-1:0]    iss_base_ext;
    logic                iss_ok;
    logic                word_full;
    logic [MAX_WORD_BITS-1:0] scan_word;
    logic [MAX_BIDX_W-1:0]    zero_idx;
    logic [BIDX_W-1:0]   free_bit;
    logic [CMP_W-1:0]    cand_frame;
    logic [CMP_W-1:0]    bit_off;

    // Effective limit: the register capped at MAX_FRAMES and at the frames the bitmap can hold.
    always_comb
    begin
        limit_in = CMP_W'(cfg_limit);
        if (limit_in > LIM_CAP_V)
        begin
            limit_in = LIM_CAP_V;
        end
    end

    // The word under test, padded with used bits above the word width.
    always_comb
    begin
        scan_word                = '1;
        scan_word[WORD_BITS-1:0] = rd_data;
    end

    // Word search helpers.
    assign frame_ext    = CMP_W'(frame_reg);
    assign iss_base_ext = CMP_W'(iss_base_reg);
    assign iss_ok       = (iss_w_reg < WORDS_V) && (iss_base_ext < limit_reg);
    assign word_full    = &rd_data;
    assign zero_idx     = lowest_zero(scan_word);
    assign free_bit     = zero_idx[BIDX_W-1:0];
    assign cand_frame   = CMP_W'(chk_base_reg) + CMP_W'(free_bit);
    assign bit_off      = frame_ext - iss_base_ext;

    assign in_stall  = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    // Sequencer: allocate reads one word a cycle, free walks to its word.
    always_comb
    begin
        state_next    = state_reg;
        frame_next    = frame_reg;
        limit_next    = limit_reg;
        iss_w_next    = iss_w_reg;
        iss_base_next = iss_base_reg;
        chk_pend_next = chk_pend_reg;
        chk_w_next    = chk_w_reg;
        chk_base_next = chk_base_reg;
        bit_next      = bit_reg;
        res_next      = res_reg;
        rd_en         = 1'b0;
        rd_addr       = iss_w_reg[WIDX_W-1:0];
        wr_en         = 1'b0;
        wr_addr       = chk_w_reg;
        wr_data       = rd_data;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    frame_next    = frame;
                    limit_next    = limit_in;
                    iss_w_next    = '0;
                    iss_base_next = '0;
                    chk_pend_next = 1'b0;
                    state_next    = (cmd == CMD_ALLOC) ? S_SCAN : S_FWALK;
                end
            end
            S_SCAN:
            begin
                if (chk_pend_reg && !word_full)
                begin
                    // First word with a clear bit ends the search either way.
                    if (cand_frame < limit_reg)
                    begin
                        wr_en              = 1'b1;
                        wr_data            = rd_data | (WORD_BITS'(1) << free_bit);
                        res_next.status    = STATUS_OK;
                        res_next.frame_out = cand_frame[FRAME_W-1:0];
                    end
                    else
                    begin
                        res_next.status    = STATUS_NO_FREE;
                        res_next.frame_out = '0;
                    end
                    state_next = S_DONE;
                end
                else if (!iss_ok)
                begin
                    res_next.status    = STATUS_NO_FREE;
                    res_next.frame_out = '0;
                    state_next         = S_DONE;
                end
                else
                begin
                    rd_en         = 1'b1;
                    chk_pend_next = 1'b1;
                    chk_w_next    = iss_w_reg[WIDX_W-1:0];
                    chk_base_next = iss_base_reg;
                    iss_w_next    = iss_w_reg + ICNT_W'(1);
                    iss_base_next = iss_base_reg + WB_STEP;
                end
            end
            S_FWALK:
            begin
                if (frame_ext >= limit_reg)
                begin
                    res_next.status    = STATUS_RANGE;
                    res_next.frame_out = '0;
                    state_next         = S_DONE;
                end
                else if (frame_ext < iss_base_ext + WB_V)
                begin
                    rd_en      = 1'b1;
                    chk_w_next = iss_w_reg[WIDX_W-1:0];
                    bit_next   = bit_off[BIDX_W-1:0];
                    state_next = S_FMOD;
                end
                else
                begin
                    iss_w_next    = iss_w_reg + ICNT_W'(1);
                    iss_base_next = iss_base_reg + WB_STEP;
                end
            end
            S_FMOD:
            begin
                wr_en              = 1'b1;
                wr_data            = rd_data & ~(WORD_BITS'(1) << bit_reg);
                res_next.status    = STATUS_OK;
                res_next.frame_out = '0;
                state_next         = S_DONE;
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            chk_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            chk_pend_reg <= chk_pend_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        frame_reg    <= frame_next;
        limit_reg    <= limit_next;
        iss_w_reg    <= iss_w_next;
        iss_base_reg <= iss_base_next;
        chk_w_reg    <= chk_w_next;
        chk_base_reg <= chk_base_next;
        bit_reg      <= bit_next;
        res_reg      <= res_next;
    end

endmodule

/* design/bitmap_frame_allocator_core.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// in        in         in_valid / in_stall   cmd, frame
// out       out        out_valid / out_stall status, frame_out
// cfg       in         cfg_valid / cfg_ready cfg_limit
//
// An allocate reads at most MAP_WORDS bitmap words; the single read port of the bitmap
// memory delivers one word a cycle.
// A free in range walks one word a cycle to its word.
// Reset clears the per-word valid bits at once, so the bitmap reads as all free.
// A new request is taken while an earlier result still waits in the output register.

module bitmap_frame_allocator_core #(
    parameter int MAX_FRAMES = bfa_pkg::MAX_FRAMES_DEF,
    parameter int WORD_BITS  = bfa_pkg::WORD_BITS_DEF,
    parameter int MAP_WORDS  = bfa_pkg::MAP_WORDS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          cmd,
    input  logic [bfa_pkg::FRAME_W-1:0]   frame,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [bfa_pkg::STATUS_W-1:0]  status,
    output logic [bfa_pkg::FRAME_W-1:0]   frame_out,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bfa_pkg::LIMIT_W-1:0]   cfg_limit
);

    import bfa_pkg::*;

    localparam int WIDX_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    logic [LIMIT_W-1:0]   limit_reg;
    logic                 out_valid_reg;
    res_t                 out_reg;
    logic                 mem_rd_en;
    logic [WIDX_W-1:0]    mem_rd_addr;
    logic [WORD_BITS-1:0] mem_rd_data;
    logic                 mem_wr_en;
    logic [WIDX_W-1:0]    mem_wr_addr;
    logic [WORD_BITS-1:0] mem_wr_data;
    logic                 res_valid;
    logic                 res_take;
    res_t                 res;

    // Frame limit register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            limit_reg <= cfg_limit;
        end
    end

    bfa_map_mem #(
        .WORD_BITS (WORD_BITS),
        .MAP_WORDS (MAP_WORDS)
    ) u_map_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    bfa_ctrl #(
        .MAX_FRAMES (MAX_FRAMES),
        .WORD_BITS  (WORD_BITS),
        .MAP_WORDS  (MAP_WORDS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .frame       (frame),
        .cfg_limit   (limit_reg),
        .rd_en       (mem_rd_en),
        .rd_addr     (mem_rd_addr),
        .rd_data     (mem_rd_data),
        .wr_en       (mem_wr_en),
        .wr_addr     (mem_wr_addr),
        .wr_data     (mem_wr_data),
        .res_valid   (res_valid),
        .res_take    (res_take),
        .res         (res)
    );

    // Output register; a result moves in when the slot is empty or drains this cycle.
    assign res_take = res_valid && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_reg.status;
    assign frame_out = out_reg.frame_out;

    // A result that is not a successful allocation carries frame zero.
    a_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != STATUS_OK) |-> frame_out == '0)
        else $error("non-ok result with nonzero frame");

    // The controller never holds a result while it takes new transactions.
    a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !res_valid)
        else $error("result pending while idle");

    // An accepted transaction keeps the input stalled in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after accept");

    // The bitmap is only modified while a request is in flight.
    a_write_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |-> (in_stall && !res_valid))
        else $error("bitmap write outside a request");

endmodule

/* tb/bitmap_frame_allocator_core_tb.sv */
`timescale 1ns / 1ps

module bitmap_frame_allocator_core_tb;
    import bfa_pkg::*;

    localparam int MAP_WORDS     = MAP_WORDS_DEF;
    localparam int WORD_BITS     = WORD_BITS_DEF;
    localparam int FRAME_CAP     = MAX_FRAMES_DEF;
    localparam int MAX_REPORTS   = 10;
    localparam int MAX_IDLE      = 12;
    localparam int SETTLE_CYCLES = MAP_WORDS + 16;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               in_valid    = 1'b0;
    logic               in_stall;
    logic               cmd         = CMD_ALLOC;
    logic [FRAME_W-1:0] frame       = '0;
    logic               out_valid;
    logic               out_stall   = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [FRAME_W-1:0] frame_out;
    logic               cfg_valid   = 1'b0;
    logic               cfg_ready;
    logic [LIMIT_W-1:0] cfg_limit   = '0;

    // Shadow copy of the bitmap and the limit register.
    logic [WORD_BITS-1:0] shadow_map [MAP_WORDS];
    logic [LIMIT_W-1:0]   shadow_limit;

    // Frames currently handed out, used to aim free requests at live frames.
    int   held_frames[$];
    res_t awaited_responses[$];

    bit send_burst = 1'b0;
    bit recv_burst = 1'b0;

    int mismatches     = 0;
    int responses_seen = 0;
    int grants         = 0;
    int exhaustions    = 0;
    int frees_done     = 0;
    int range_rejects  = 0;
    int limit_writes   = 0;

    bitmap_frame_allocator_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .frame       (frame),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .frame_out   (frame_out),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_limit   (cfg_limit)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Run limit, far above the slowest legal run.
    initial
    begin
        #12_000_000;
        $display("Timeout with %0d responses outstanding.", awaited_responses.size());
        $display("bitmap_frame_allocator_core regression: fail");
        $finish;
    end

    // The limit in force: the register value capped at the bitmap size.
    function automatic int usable_limit();
        return (int'(shadow_limit) > FRAME_CAP) ? FRAME_CAP : int'(shadow_limit);
    endfunction

    // Computes the response to one request and updates the shadow bitmap.
    function automatic res_t frame_response(input logic op, input logic [FRAME_W-1:0] target);
        res_t r;
        int   usable;
        logic found;
        usable      = usable_limit();
        found       = 1'b0;
        r.status    = STATUS_NO_FREE;
        r.frame_out = '0;
        if (op == CMD_ALLOC)
        begin
            // First fit: lowest clear bit of the first word that is not full.
            for (int w = 0; w < MAP_WORDS && !found; w++)
            begin
                if (w * WORD_BITS >= usable)
                    break;
                if (&shadow_map[w])
                    continue;
                for (int b = 0; b < WORD_BITS; b++)
                begin
                    if (!shadow_map[w][b])
                    begin
                        if (w * WORD_BITS + b < usable)
                        begin
                            shadow_map[w][b] = 1'b1;
                            r.status         = STATUS_OK;
                            r.frame_out      = FRAME_W'(w * WORD_BITS + b);
                            held_frames.push_back(w * WORD_BITS + b);
                        end
                        found = 1'b1;
                        break;
                    end
                end
            end
            if (r.status == STATUS_OK)
                grants++;
            else
                exhaustions++;
        end
        else if (int'(target) >= usable)
        begin
            r.status = STATUS_RANGE;
            range_rejects++;
        end
        else
        begin
            shadow_map[int'(target) / WORD_BITS][int'(target) % WORD_BITS] = 1'b0;
            r.status = STATUS_OK;
            frees_done++;
            for (int i = 0; i < held_frames.size(); i++)
            begin
                if (held_frames[i] == int'(target))
                begin
                    held_frames.delete(i);
                    break;
                end
            end
        end
        return r;
    endfunction

    // Picks a frame to free: mostly a live one, sometimes a stray or free one.
    function automatic logic [FRAME_W-1:0] pick_free_target();
        int roll;
        int upper;
        roll  = $urandom_range(0, 99);
        upper = usable_limit() + 8;
        if (upper > FRAME_CAP - 1)
            upper = FRAME_CAP - 1;
        if (roll < 65 && held_frames.size() > 0)
            return FRAME_W'(held_frames[$urandom_range(0, held_frames.size() - 1)]);
        if (roll < 85)
            return FRAME_W'($urandom_range(0, upper));
        return FRAME_W'($urandom);
    endfunction

    // Sends one request transaction and records its expected response.
    task automatic send_request(input logic op, input logic [FRAME_W-1:0] target);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= op;
        frame    <= target;
        awaited_responses.push_back(frame_response(op, target));
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Holds off new requests until every response has come back.
    task automatic wait_for_responses();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_responses.size() != 0);
    endtask

    // Writes the frame limit once the block is idle.
    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        wait_for_responses();
        cfg_valid <= 1'b1;
        cfg_limit <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid    <= 1'b0;
        shadow_limit = value;
        limit_writes++;
    endtask

    // One phase of random traffic under a given limit.
    task automatic run_churn(input logic [LIMIT_W-1:0] limit_value, input int count,
                             input int alloc_pct);
        write_limit(limit_value);
        for (int i = 0; i < count; i++)
        begin
            if (i % 80 == 0)
            begin
                send_burst = ($urandom_range(0, 3) == 0);
                recv_burst = ($urandom_range(0, 3) == 0);
            end
            // Let the pipeline run dry halfway through each phase.
            if (i == count / 2)
                wait_for_responses();
            if ($urandom_range(0, 99) < alloc_pct)
                send_request(CMD_ALLOC, FRAME_W'($urandom));
            else
                send_request(CMD_FREE, pick_free_target());
        end
    endtask

    // Default limit after reset: first fit, reuse of a freed frame, double free.
    task automatic test_reset_defaults();
        send_request(CMD_ALLOC, 12'd0);
        send_request(CMD_ALLOC, 12'd0);
        send_request(CMD_ALLOC, 12'd0);
        send_request(CMD_FREE, 12'd1);
        send_request(CMD_ALLOC, 12'd0);
        send_request(CMD_FREE, 12'd4095);
        send_request(CMD_FREE, 12'd2);
        send_request(CMD_FREE, 12'd2);
        send_request(CMD_ALLOC, 12'hFFF);
    endtask

    // Zero limit, a one-frame pool, and a register value above the bitmap size.
    task automatic test_limit_extremes();
        write_limit(13'd0);
        send_request(CMD_ALLOC, 12'd0);
        send_request(CMD_FREE, 12'd0);
        send_request(CMD_FREE, 12'd4095);
        write_limit(13'd1);
        send_request(CMD_ALLOC, 12'd0);
        send_request(CMD_FREE, 12'd0);
        send_request(CMD_ALLOC, 12'd0);
        send_request(CMD_ALLOC, 12'd0);
        send_request(CMD_FREE, 12'd1);
        write_limit(13'h1FFF);
        send_request(CMD_FREE, 12'd4095);
        send_request(CMD_ALLOC, 12'd0);
    endtask

    // Small pools, including a limit that ends inside a word, driven to exhaustion.
    task automatic test_small_pool_exhaustion();
        run_churn(13'd40, 220, 70);
        run_churn(13'd161, 260, 65);
    endtask

    // Limit dropped below frames still in use; those frames stay stuck.
    task automatic test_limit_lowered();
        run_churn(13'd17, 120, 50);
        run_churn(13'd0, 30, 50);
        run_churn(13'd1, 50, 50);
    endtask

    // Full-size pool with allocation-heavy traffic to push the scan deeper.
    task automatic test_deep_scan();
        run_churn(LIMIT_RESET, 500, 80);
        run_churn(13'h1FFF, 200, 55);
    endtask

    task automatic test_random_limits();
        for (int p = 0; p < 3; p++)
            run_churn(LIMIT_W'($urandom_range(2, 600)), 150, $urandom_range(35, 75));
    endtask

    // Response side: random stall per transaction, compare with the oldest expectation.
    initial
    begin : response_checker
        int   hold;
        res_t want;
        wait (rst_n === 1'b1);
        forever
        begin
            hold = recv_burst ? 0 : $urandom_range(0, MAX_IDLE);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
            responses_seen++;
            if (awaited_responses.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: response with nothing expected: status %0d frame_out %0d",
                             $time, status, frame_out);
            end
            else
            begin
                want = awaited_responses.pop_front();
                if (status !== want.status || frame_out !== want.frame_out)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: status exp %0d got %0d, frame_out exp %0d got %0d",
                                 $time, want.status, status, want.frame_out, frame_out);
                end
            end
        end
    end

    initial
    begin : stimulus
        for (int w = 0; w < MAP_WORDS; w++)
            shadow_map[w] = '0;
        shadow_limit = LIMIT_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_limit_extremes();
        test_small_pool_exhaustion();
        test_limit_lowered();
        test_deep_scan();
        test_random_limits();

        // Drain, then watch for stray responses.
        wait_for_responses();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (awaited_responses.size() != 0)
        begin
            mismatches++;
            $display("%0d responses never arrived.", awaited_responses.size());
        end

        $display("Covered %0d grants, %0d exhausted allocations, %0d frees, %0d range rejects",
                 grants, exhaustions, frees_done, range_rejects);
        $display("across %0d limit settings; %0d responses checked, %0d mismatches.",
                 limit_writes, responses_seen, mismatches);
        if (mismatches == 0)
            $display("bitmap_frame_allocator_core regression: pass");
        else
            $display("bitmap_frame_allocator_core regression: fail");
        $finish;
    end

endmodule
